/* rtl/srt_pkg.sv */
// Package for the slice reassembly tracker: item types, register map,
// operation codes and sequencer states. No dependencies.
`default_nettype none

package srt_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int MAX_SLICES   = 256;

    localparam logic [7:0] NO_TERMINAL = 8'hFF;

    // Dividend of the ring modulo is at most 254 + 255, which fits 9 bits.
    localparam int MOD_BITS = 9;
    localparam int STEP_W   = 4;

    localparam int PADDR_W = 3;

    localparam logic REG_BLOCK_BYTES = 1'b0;
    localparam logic REG_SLOT_COUNT  = 1'b1;

    localparam logic [15:0] BLOCK_BYTES_RST = 16'd64;
    localparam logic [7:0]  SLOT_COUNT_RST  = 8'd16;

    localparam logic OP_SLICE   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  slice_number;
        logic [15:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] store_slot;
        logic       just_completed;
        logic [7:0] ring_head;
        logic [7:0] ring_tail;
        logic       package_ready;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT,
        S_UPDATE,
        S_HEAD,
        S_RELEASE,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

/* rtl/slice_reassembly_tracker.sv */
// Slice item: 9 modulo steps for the store slot (S_SLOT), S_UPDATE, then S_OUT registers
// the result; a completing slice runs 9 more modulo steps for the head (S_HEAD) before S_OUT.
// Release item: S_RELEASE, then S_OUT. The input stalls until the result is registered, and
// longer while a stalled result holds the output register. One shared modulo unit serves both.
// Synchronous active-low reset clears state and bitmap; registers return to 64 and 16.
// Depends on srt_pkg.
`default_nettype none

module slice_reassembly_tracker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  srt_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output srt_pkg::t_out_item            o_out_item,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [srt_pkg::PADDR_W-1:0]   paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import srt_pkg::*;

    t_state          r_state, n_state;
    logic [15:0]     r_block_bytes;
    logic [7:0]      r_slot_count;
    logic [7:0]      r_base, n_base;
    logic [MAX_SLICES-1:0] r_seen, n_seen;
    logic [8:0]      r_count, n_count;
    logic [7:0]      r_last, n_last;
    logic [7:0]      r_head, n_head;
    logic [7:0]      r_tail, n_tail;
    logic            r_ready, n_ready;
    t_in_item        r_item, n_item;
    logic [7:0]      r_slot, n_slot;
    logic            r_done, n_done;
    logic [MOD_BITS-1:0] r_dvd, n_dvd;
    logic [7:0]      r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out_item, n_out_item;

    logic            in_acc;
    logic            cfg_we;
    logic [7:0]      eff_count;
    logic [8:0]      mod_t;
    logic [7:0]      rem_nx;
    logic            step_last;
    logic [15:0]     limit;
    logic            was_seen;
    logic [8:0]      upd_count;
    logic [7:0]      upd_last;
    logic            complete;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_we     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        unique case (paddr[2])
            REG_BLOCK_BYTES: prdata = {16'd0, r_block_bytes};
            REG_SLOT_COUNT:  prdata = {24'd0, r_slot_count};
            default:         prdata = 32'd0;
        endcase
    end

    // Shared modulo unit: one restoring step per cycle, the dividend shifting out MSB first.
    assign eff_count = (r_slot_count == 8'd0) ? 8'd1 : r_slot_count;
    assign mod_t     = {r_rem, r_dvd[MOD_BITS-1]};
    assign rem_nx    = (mod_t >= {1'b0, eff_count}) ? 8'(mod_t - {1'b0, eff_count})
                                                     : mod_t[7:0];
    assign step_last = (r_step == STEP_W'(MOD_BITS - 1));

    // Bitmap, count and terminal as they stand after the latched slice.
    assign limit     = (r_block_bytes > 16'(HEADER_BYTES))
                       ? (r_block_bytes - 16'(HEADER_BYTES)) : 16'd0;
    assign was_seen  = r_seen[r_item.slice_number];
    always_comb begin
        upd_count = r_count;
        upd_last  = r_last;
        if ({1'b0, r_item.slice_number} < 9'(MAX_SLICES)) begin
            if (!was_seen) begin
                upd_count = r_count + 9'd1;
            end
            if (r_item.payload_length < limit) begin
                upd_last = r_item.slice_number;
            end
        end
    end
    assign complete = (upd_last != NO_TERMINAL) && (upd_count >= ({1'b0, upd_last} + 9'd1));

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_seen      = r_seen;
        n_count     = r_count;
        n_last      = r_last;
        n_head      = r_head;
        n_tail      = r_tail;
        n_ready     = r_ready;
        n_item      = r_item;
        n_slot      = r_slot;
        n_done      = r_done;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_item = i_in_item;
                    if (i_in_item.operation == OP_RELEASE) begin
                        n_state = S_RELEASE;
                    end else begin
                        n_dvd   = {1'b0, r_base} + {1'b0, i_in_item.slice_number};
                        n_rem   = 8'd0;
                        n_step  = '0;
                        n_state = S_SLOT;
                    end
                end
            end
            S_SLOT: begin
                n_dvd  = r_dvd << 1;
                n_rem  = rem_nx;
                n_step = r_step + STEP_W'(1);
                if (step_last) begin
                    n_slot  = rem_nx;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if ({1'b0, r_item.slice_number} < 9'(MAX_SLICES)) begin
                    n_seen[r_item.slice_number] = 1'b1;
                end
                n_count = upd_count;
                n_last  = upd_last;
                if (complete) begin
                    n_dvd   = {1'b0, r_base} + {1'b0, upd_last} + 9'd1;
                    n_rem   = 8'd0;
                    n_step  = '0;
                    n_state = S_HEAD;
                end else begin
                    n_done  = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_HEAD: begin
                n_dvd  = r_dvd << 1;
                n_rem  = rem_nx;
                n_step = r_step + STEP_W'(1);
                if (step_last) begin
                    n_head  = rem_nx;
                    n_base  = rem_nx;
                    n_ready = 1'b1;
                    n_seen  = '0;
                    n_count = 9'd0;
                    n_last  = NO_TERMINAL;
                    n_done  = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_RELEASE: begin
                n_tail  = r_head;
                n_ready = 1'b0;
                n_slot  = 8'd0;
                n_done  = 1'b0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid                = 1'b1;
                    n_out_item.store_slot      = r_slot;
                    n_out_item.just_completed  = r_done;
                    n_out_item.ring_head       = r_head;
                    n_out_item.ring_tail       = r_tail;
                    n_out_item.package_ready   = r_ready;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= 8'd0;
            r_seen      <= '0;
            r_count     <= 9'd0;
            r_last      <= NO_TERMINAL;
            r_head      <= 8'd0;
            r_tail      <= 8'd0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_seen      <= n_seen;
            r_count     <= n_count;
            r_last      <= n_last;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_slot     <= n_slot;
        r_done     <= n_done;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_out_item <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RST;
            r_slot_count  <= SLOT_COUNT_RST;
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_BLOCK_BYTES: r_block_bytes <= pwdata[15:0];
                REG_SLOT_COUNT:  r_slot_count  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Ready is only ever raised by the last step of the head computation.
    a_ready_from_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ready) |-> $past(r_state == S_HEAD))
        else $error("package ready raised outside head computation");

    // The unique count can never exceed the number of distinct serials.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 9'(MAX_SLICES))
        else $error("unique slice count out of range");

    // A completing result always reports a ready package.
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.just_completed) |-> r_out_item.package_ready)
        else $error("completed package not flagged ready");

    // After a completion the tracking state is back to empty.
    a_clear_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD && step_last) |=> (r_count == 9'd0 && r_last == NO_TERMINAL))
        else $error("tracking state not cleared after completion");
`endif

endmodule

`default_nettype wire

/* tb/slice_reassembly_tracker_tb.sv */
// Self-checking testbench for slice_reassembly_tracker: directed and random slice and
// release items through valid/stall channels, register writes over the APB-style port.
// Depends on srt_pkg and the slice_reassembly_tracker RTL.

module slice_reassembly_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srt_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 30;
    localparam int ITEM_TARGET  = 1400;
    localparam int PHASE_ITEMS  = 200;
    localparam int REPORT_MAX   = 10;

    // Tracks the ring state alongside the block and keeps the results it should produce.
    class slice_scoreboard;
        logic [15:0]  cfg_block_bytes;
        logic [7:0]   cfg_slot_count;
        logic [7:0]   base_slot;
        logic [255:0] seen_map;
        logic [8:0]   unique_count;
        logic [7:0]   last_serial;
        logic [7:0]   head_slot;
        logic [7:0]   tail_slot;
        logic         ready_flag;
        t_out_item    expected_q[$];
        int           mismatches;

        function new();
            cfg_block_bytes = BLOCK_BYTES_RST;
            cfg_slot_count  = SLOT_COUNT_RST;
            base_slot       = '0;
            seen_map        = '0;
            unique_count    = '0;
            last_serial     = NO_TERMINAL;
            head_slot       = '0;
            tail_slot       = '0;
            ready_flag      = 1'b0;
            mismatches      = 0;
        endfunction

        // A slot count of zero behaves as a ring of one block.
        function logic [7:0] ring_slot(int unsigned sum);
            int unsigned blocks;
            blocks = (cfg_slot_count == 0) ? 1 : cfg_slot_count;
            return 8'(sum % blocks);
        endfunction

        function void note_item(t_in_item it);
            t_out_item   exp;
            int unsigned limit;
            exp = '0;
            if (it.operation == OP_RELEASE) begin
                tail_slot  = head_slot;
                ready_flag = 1'b0;
            end else begin
                exp.store_slot = ring_slot(int'(base_slot) + int'(it.slice_number));
                if (int'(it.slice_number) < MAX_SLICES) begin
                    limit = (cfg_block_bytes > HEADER_BYTES) ? cfg_block_bytes - HEADER_BYTES : 0;
                    if (!seen_map[it.slice_number]) begin
                        seen_map[it.slice_number] = 1'b1;
                        unique_count = unique_count + 9'd1;
                    end
                    if (it.payload_length < limit) begin
                        last_serial = it.slice_number;
                    end
                end
                if (last_serial != NO_TERMINAL
                    && int'(unique_count) >= int'(last_serial) + 1) begin
                    head_slot          = ring_slot(int'(base_slot) + int'(last_serial) + 1);
                    ready_flag         = 1'b1;
                    base_slot          = head_slot;
                    seen_map           = '0;
                    unique_count       = '0;
                    last_serial        = NO_TERMINAL;
                    exp.just_completed = 1'b1;
                end
            end
            exp.ring_head     = head_slot;
            exp.ring_tail     = tail_slot;
            exp.package_ready = ready_flag;
            expected_q.push_back(exp);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            bit        bad;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result: slot %0d done %0d head %0d tail %0d ready %0d",
                             got.store_slot, got.just_completed, got.ring_head, got.ring_tail,
                             got.package_ready);
                end
                return;
            end
            exp = expected_q.pop_front();
            bad = 1'b0;
            if (got.store_slot !== exp.store_slot) bad = 1'b1;
            if (got.just_completed !== exp.just_completed) bad = 1'b1;
            if (got.ring_head !== exp.ring_head) bad = 1'b1;
            if (got.ring_tail !== exp.ring_tail) bad = 1'b1;
            if (got.package_ready !== exp.package_ready) bad = 1'b1;
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch: expected slot %0d done %0d head %0d tail %0d ready %0d",
                             exp.store_slot, exp.just_completed, exp.ring_head, exp.ring_tail,
                             exp.package_ready);
                    $display("          actual   slot %0d done %0d head %0d tail %0d ready %0d",
                             got.store_slot, got.just_completed, got.ring_head, got.ring_tail,
                             got.package_ready);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_stall;
    t_in_item            in_item;
    logic                out_valid;
    logic                out_stall;
    t_out_item           out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    slice_scoreboard     sb;
    int                  cycles = 0;
    int                  items_sent;
    bit                  calm;

    slice_reassembly_tracker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("slice_reassembly_tracker_tb NOT OK");
            $finish;
        end
    end

    // Calm phases run both sides without any idling.
    function int draw_gap();
        if (calm || $urandom_range(3, 0) == 0) begin
            return 0;
        end
        return $urandom_range(MAX_GAP, 0);
    endfunction

    function int unsigned payload_limit();
        return (sb.cfg_block_bytes > HEADER_BYTES) ? sb.cfg_block_bytes - HEADER_BYTES : 0;
    endfunction

    function logic [15:0] full_payload();
        return 16'($urandom_range(65535, payload_limit()));
    endfunction

    function logic [15:0] short_payload();
        if (payload_limit() == 0) begin
            return 16'($urandom_range(65535, 0));
        end
        return 16'($urandom_range(payload_limit() - 1, 0));
    endfunction

    function t_in_item slice_item(logic [7:0] serial, logic [15:0] payload);
        t_in_item it;
        it.operation      = OP_SLICE;
        it.slice_number   = serial;
        it.payload_length = payload;
        return it;
    endfunction

    // The serial and payload of a release item are ignored, so they carry noise.
    function t_in_item release_item();
        t_in_item it;
        it.operation      = OP_RELEASE;
        it.slice_number   = 8'($urandom_range(255, 0));
        it.payload_length = 16'($urandom_range(65535, 0));
        return it;
    endfunction

    // Result side: stall for a random number of cycles, then take one item.
    initial begin
        out_stall = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            int gap;
            gap = draw_gap();
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (out_valid !== 1'b1);
            sb.check_result(out_item);
        end
    end

    task automatic send_item(t_in_item it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic reg_idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_BLOCK_BYTES) begin
            sb.cfg_block_bytes = value[15:0];
        end else begin
            sb.cfg_slot_count = value[7:0];
        end
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] block_bytes, logic [7:0] slot_count);
        wait_drained();
        write_reg(REG_BLOCK_BYTES, {16'd0, block_bytes});
        write_reg(REG_SLOT_COUNT, {24'd0, slot_count});
    endtask

    // Slices 0..len-1 in shuffled order; only the last serial is short.
    task automatic send_package(int len);
        int order[256];
        int j;
        int tmp;
        for (int i = 0; i < len; i++) order[i] = i;
        for (int i = len - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < len; i++) begin
            if (order[i] == len - 1) begin
                send_item(slice_item(8'(order[i]), short_payload()));
            end else begin
                send_item(slice_item(8'(order[i]), full_payload()));
            end
            if ($urandom_range(9, 0) == 0) begin
                send_item(slice_item(8'(order[$urandom_range(i, 0)]), full_payload()));
            end
        end
    endtask

    task automatic send_noise();
        if ($urandom_range(3, 0) == 0) begin
            send_item(release_item());
        end else begin
            send_item(slice_item(8'($urandom_range(255, 0)), 16'($urandom_range(65535, 0))));
        end
    endtask

    initial begin
        int next_phase;
        int pick;
        int len;
        int r;

        sb         = new();
        items_sent = 0;
        calm       = 1'b0;
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: 64-byte blocks leave a 60-byte payload limit, ring of 16.
        send_item(slice_item(8'd0, 16'hFFFF));
        send_item(slice_item(8'd0, 16'hFFFF));
        send_item(slice_item(8'd1, 16'd0));
        send_item(release_item());
        send_item(release_item());
        // A short slice with serial 255 leaves the terminal unknown.
        send_item(slice_item(8'hFF, 16'd59));
        send_item(slice_item(8'd0, 16'd0));
        // Completing again while the previous package is still unread.
        send_item(slice_item(8'd0, 16'd0));
        send_item(release_item());
        send_item(slice_item(8'd200, 16'd60));
        send_item(slice_item(8'd254, 16'd0));
        send_item(release_item());

        // A block smaller than the header, and a ring of zero blocks.
        set_config(16'd2, 8'd0);
        send_item(slice_item(8'd7, 16'd0));
        send_item(slice_item(8'hFF, 16'd0));
        send_item(release_item());
        set_config(16'd4, 8'd1);
        send_item(slice_item(8'd3, 16'd0));
        send_item(slice_item(8'd0, 16'd0));
        set_config(16'd5, 8'd1);
        send_item(slice_item(8'd0, 16'd0));
        send_item(slice_item(8'd1, 16'd1));
        // Largest block and ring sizes; the ring of one block has left the base at zero.
        set_config(16'hFFFF, 8'd255);
        send_item(slice_item(8'd254, 16'd65531));
        send_item(slice_item(8'd3, 16'd65530));
        send_item(release_item());

        next_phase = items_sent;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= next_phase) begin
                pick = $urandom_range(5, 0);
                case (pick)
                    0: begin
                        set_config(16'hFFFF, 8'd255);
                    end
                    1: begin
                        set_config(16'd5, 8'd1);
                    end
                    2: begin
                        set_config(16'($urandom_range(4, 0)), 8'd0);
                    end
                    default: begin
                        set_config(16'($urandom_range(2000, 5)), 8'($urandom_range(255, 1)));
                    end
                endcase
                calm       = ($urandom_range(3, 0) == 0);
                next_phase = items_sent + PHASE_ITEMS;
            end
            r = $urandom_range(99, 0);
            if (r < 70) begin
                len = (r == 0) ? $urandom_range(255, 100) : $urandom_range(12, 1);
                send_package(len);
                if ($urandom_range(9, 0) < 7) begin
                    send_item(release_item());
                end
            end else if (r < 74) begin
                wait_drained();
            end else begin
                send_noise();
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("slice_reassembly_tracker_tb OK");
        end else begin
            $display("slice_reassembly_tracker_tb NOT OK");
        end
        $finish;
    end

endmodule
